>>> hw/rtl/chp_pkg.sv
// shared constants, point type and cell control structs for the convex hull block
package chp_pkg;

    localparam int C_MAX_POINTS = 64;
    localparam int C_COORD_BITS = 16;
    localparam int C_CNT_W      = $clog2(C_MAX_POINTS + 1);
    localparam int C_IDX_W      = $clog2(C_MAX_POINTS);

    typedef struct packed {
        logic [C_COORD_BITS-1:0] x;
        logic [C_COORD_BITS-1:0] y;
    } t_point;

    // sort chain operations
    localparam logic [1:0] SORT_HOLD  = 2'd0;
    localparam logic [1:0] SORT_INS   = 2'd1;
    localparam logic [1:0] SORT_SHIFT = 2'd2;

    // stack chain operations
    localparam logic [1:0] STK_HOLD = 2'd0;
    localparam logic [1:0] STK_PUSH = 2'd1;
    localparam logic [1:0] STK_POP  = 2'd2;

    typedef struct packed {
        logic [1:0] op;
        t_point     new_pt;
        t_point     anchor;
    } t_sort_ctl;

    typedef struct packed {
        logic [1:0] op;
    } t_stack_ctl;

endpackage

>>> hw/rtl/chp_in_if.sv
// point request channel
interface chp_in_if import chp_pkg::*;;
    logic                    valid;
    logic                    ready;
    logic [C_COORD_BITS-1:0] point_x;
    logic [C_COORD_BITS-1:0] point_y;
    logic                    point_last;

    modport source (output valid, output point_x, output point_y, output point_last,
                    input ready);
    modport sink   (input valid, input point_x, input point_y, input point_last,
                    output ready);
endinterface

>>> hw/rtl/chp_out_if.sv
// hull vertex request channel
interface chp_out_if import chp_pkg::*;;
    logic                    valid;
    logic                    ready;
    logic [C_COORD_BITS-1:0] hull_x;
    logic [C_COORD_BITS-1:0] hull_y;
    logic                    hull_last;

    modport source (output valid, output hull_x, output hull_y, output hull_last,
                    input ready);
    modport sink   (input valid, input hull_x, input hull_y, input hull_last,
                    output ready);
endinterface

>>> hw/rtl/chp_sort_cell.sv
// one cell of the angle-sorted insertion chain
module chp_sort_cell import chp_pkg::*; (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  t_sort_ctl i_ctl,
    input  t_point    i_left_pt,
    input  logic      i_left_vld,
    input  logic      i_left_b,
    input  t_point    i_right_pt,
    input  logic      i_right_vld,
    input  logic      i_right_b,
    output t_point    o_pt,
    output logic      o_vld,
    output logic      o_b
);
    t_point r_pt;
    logic   r_vld;
    logic   r_gt;

    logic signed [C_COORD_BITS:0]     w_dxc, w_dyc, w_dxn, w_dyn;
    logic signed [2*C_COORD_BITS+1:0] w_lhs, w_rhs;

    assign w_dxc = $signed({1'b0, r_pt.x}) - $signed({1'b0, i_ctl.anchor.x});
    assign w_dyc = $signed({1'b0, r_pt.y}) - $signed({1'b0, i_ctl.anchor.y});
    assign w_dxn = $signed({1'b0, i_ctl.new_pt.x}) - $signed({1'b0, i_ctl.anchor.x});
    assign w_dyn = $signed({1'b0, i_ctl.new_pt.y}) - $signed({1'b0, i_ctl.anchor.y});
    assign w_lhs = w_dyc * w_dxn;
    assign w_rhs = w_dyn * w_dxc;

    // this cell and all to its right sort strictly after the new point
    assign o_b   = (!r_vld || r_gt) && i_right_b;
    assign o_pt  = r_pt;
    assign o_vld = r_vld;

    always_ff @(posedge i_clk) begin
        r_gt <= (w_lhs > w_rhs);
        case (i_ctl.op)
            SORT_INS: begin
                if (o_b) begin
                    r_pt <= i_left_b ? i_left_pt : i_ctl.new_pt;
                end
            end
            SORT_SHIFT: r_pt <= i_right_pt;
            default: r_pt <= r_pt;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= 1'b0;
        end else begin
            case (i_ctl.op)
                SORT_INS: begin
                    if (o_b) begin
                        r_vld <= i_left_b ? i_left_vld : 1'b1;
                    end
                end
                SORT_SHIFT: r_vld <= i_right_vld;
                default: r_vld <= r_vld;
            endcase
        end
    end
endmodule

>>> hw/rtl/chp_stack_cell.sv
// one cell of the shifting hull stack
module chp_stack_cell import chp_pkg::*; (
    input  logic       i_clk,
    input  t_stack_ctl i_ctl,
    input  t_point     i_left_pt,
    input  t_point     i_right_pt,
    output t_point     o_pt
);
    t_point r_pt;

    assign o_pt = r_pt;

    always_ff @(posedge i_clk) begin
        case (i_ctl.op)
            STK_PUSH: r_pt <= i_left_pt;
            STK_POP:  r_pt <= i_right_pt;
            default:  r_pt <= r_pt;
        endcase
    end
endmodule

>>> hw/rtl/convex_hull_graham_scan.sv
// convex hull top level: point store, sort chain, stack chain and scan control
// loading takes one point per cycle; point_last starts the run
// sorting reads each stored point, drops the first copy of the anchor, then compares and inserts the rest
// the scan takes each sorted point, pops the stack top on each strict right turn, then pushes the point
// stack alignment moves the stack bottom into the last cell, then one vertex per cycle while the receiver takes them
// synchronous active-low reset empties the sort chain, the point count and the stack depth; the store keeps data
module convex_hull_graham_scan import chp_pkg::*; (
    input  logic          i_clk,
    input  logic          i_rst_n,
    chp_in_if.sink        i_pt,
    chp_out_if.source     o_hull
);
    localparam logic [3:0] S_LOAD    = 4'd0;
    localparam logic [3:0] S_RD      = 4'd1;
    localparam logic [3:0] S_CHK     = 4'd2;
    localparam logic [3:0] S_CMP     = 4'd3;
    localparam logic [3:0] S_INS     = 4'd4;
    localparam logic [3:0] S_SC_NEXT = 4'd5;
    localparam logic [3:0] S_SC_TEST = 4'd6;
    localparam logic [3:0] S_SC_DEC  = 4'd7;
    localparam logic [3:0] S_SC_PUSH = 4'd8;
    localparam logic [3:0] S_ALIGN   = 4'd9;
    localparam logic [3:0] S_EMIT_A  = 4'd10;
    localparam logic [3:0] S_EMIT_S  = 4'd11;

    localparam logic [C_CNT_W-1:0] C_FULL = C_CNT_W'(C_MAX_POINTS);

    t_point r_mem [C_MAX_POINTS];
    t_point r_rd_data;

    logic [3:0]         r_state, n_state;
    logic [C_CNT_W-1:0] r_cnt, n_cnt;
    logic [C_CNT_W-1:0] r_rd, n_rd;
    logic [C_CNT_W-1:0] r_depth, n_depth;
    logic [C_CNT_W-1:0] r_al, n_al;
    logic [C_CNT_W-1:0] r_em, n_em;
    logic               r_removed, n_removed;
    t_point             r_anchor, n_anchor;
    t_point             r_new, n_new;
    t_point             r_cur, n_cur;
    t_point             r_out, n_out;
    logic               r_out_last, n_out_last;
    logic               r_ov, n_ov;
    logic signed [2*C_COORD_BITS+1:0] r_lhs, r_rhs;

    t_point     w_pt_in;
    logic       w_acc, w_store, w_slot;
    t_sort_ctl  w_sctl;
    t_stack_ctl w_kctl;
    t_point     w_spt  [C_MAX_POINTS];
    logic       w_svld [C_MAX_POINTS];
    logic       w_sb   [C_MAX_POINTS];
    t_point     w_kpt  [C_MAX_POINTS];
    logic signed [C_COORD_BITS:0] w_bax, w_bay, w_cax, w_cay;

    assign w_pt_in.x = i_pt.point_x;
    assign w_pt_in.y = i_pt.point_y;
    assign i_pt.ready = (r_state == S_LOAD);
    assign w_acc   = i_pt.valid && i_pt.ready;
    assign w_store = w_acc && (r_cnt < C_FULL);
    assign w_slot  = !r_ov || o_hull.ready;

    assign o_hull.valid     = r_ov;
    assign o_hull.hull_x    = r_out.x;
    assign o_hull.hull_y    = r_out.y;
    assign o_hull.hull_last = r_out_last;

    // point store
    always_ff @(posedge i_clk) begin
        if (w_store) begin
            r_mem[r_cnt[C_IDX_W-1:0]] <= w_pt_in;
        end
        r_rd_data <= r_mem[r_rd[C_IDX_W-1:0]];
    end

    // sort chain
    genvar k;
    generate
        for (k = 0; k < C_MAX_POINTS; k++) begin : g_sort
            chp_sort_cell u_cell (
                .i_clk      (i_clk),
                .i_rst_n    (i_rst_n),
                .i_ctl      (w_sctl),
                .i_left_pt  ((k == 0) ? r_new : w_spt[(k == 0) ? 0 : k-1]),
                .i_left_vld ((k == 0) ? 1'b0 : w_svld[(k == 0) ? 0 : k-1]),
                .i_left_b   ((k == 0) ? 1'b0 : w_sb[(k == 0) ? 0 : k-1]),
                .i_right_pt ((k == C_MAX_POINTS-1) ? r_new :
                             w_spt[(k == C_MAX_POINTS-1) ? k : k+1]),
                .i_right_vld((k == C_MAX_POINTS-1) ? 1'b0 :
                             w_svld[(k == C_MAX_POINTS-1) ? k : k+1]),
                .i_right_b  ((k == C_MAX_POINTS-1) ? 1'b1 :
                             w_sb[(k == C_MAX_POINTS-1) ? k : k+1]),
                .o_pt       (w_spt[k]),
                .o_vld      (w_svld[k]),
                .o_b        (w_sb[k])
            );
        end
        // stack chain, top at cell zero
        for (k = 0; k < C_MAX_POINTS; k++) begin : g_stack
            chp_stack_cell u_cell (
                .i_clk     (i_clk),
                .i_ctl     (w_kctl),
                .i_left_pt ((k == 0) ? r_cur : w_kpt[(k == 0) ? 0 : k-1]),
                .i_right_pt((k == C_MAX_POINTS-1) ? r_cur :
                            w_kpt[(k == C_MAX_POINTS-1) ? k : k+1]),
                .o_pt      (w_kpt[k])
            );
        end
    endgenerate

    // turn test of second, top and current point
    assign w_bax = $signed({1'b0, w_kpt[0].x}) - $signed({1'b0, w_kpt[1].x});
    assign w_bay = $signed({1'b0, w_kpt[0].y}) - $signed({1'b0, w_kpt[1].y});
    assign w_cax = $signed({1'b0, r_cur.x}) - $signed({1'b0, w_kpt[1].x});
    assign w_cay = $signed({1'b0, r_cur.y}) - $signed({1'b0, w_kpt[1].y});

    always_ff @(posedge i_clk) begin
        r_lhs <= w_bax * w_cay;
        r_rhs <= w_bay * w_cax;
    end

    always_comb begin
        n_state    = r_state;
        n_cnt      = r_cnt;
        n_rd       = r_rd;
        n_depth    = r_depth;
        n_al       = r_al;
        n_em       = r_em;
        n_removed  = r_removed;
        n_anchor   = r_anchor;
        n_new      = r_new;
        n_cur      = r_cur;
        n_out      = r_out;
        n_out_last = r_out_last;
        n_ov       = r_ov && !o_hull.ready;
        w_sctl.op     = SORT_HOLD;
        w_sctl.new_pt = r_new;
        w_sctl.anchor = r_anchor;
        w_kctl.op  = STK_HOLD;
        case (r_state)
            S_LOAD: begin
                if (w_store) begin
                    n_cnt = r_cnt + 1'b1;
                    if (w_pt_in.y < r_anchor.y ||
                        (w_pt_in.y == r_anchor.y && w_pt_in.x < r_anchor.x)) begin
                        n_anchor = w_pt_in;
                    end
                end
                if (w_acc && i_pt.point_last) begin
                    n_rd      = '0;
                    n_removed = 1'b0;
                    n_state   = S_RD;
                end
            end
            S_RD: begin
                if (r_rd == r_cnt) begin
                    n_state = S_SC_NEXT;
                end else begin
                    n_rd    = r_rd + 1'b1;
                    n_state = S_CHK;
                end
            end
            S_CHK: begin
                if (!r_removed && r_rd_data == r_anchor) begin
                    n_removed = 1'b1;
                    n_state   = S_RD;
                end else begin
                    n_new   = r_rd_data;
                    n_state = S_CMP;
                end
            end
            S_CMP: n_state = S_INS;
            S_INS: begin
                w_sctl.op = SORT_INS;
                n_state   = S_RD;
            end
            S_SC_NEXT: begin
                if (!w_svld[0]) begin
                    n_al    = r_depth;
                    n_state = S_ALIGN;
                end else begin
                    n_cur     = w_spt[0];
                    w_sctl.op = SORT_SHIFT;
                    n_state   = S_SC_TEST;
                end
            end
            S_SC_TEST: n_state = (r_depth > C_CNT_W'(1)) ? S_SC_DEC : S_SC_PUSH;
            S_SC_DEC: begin
                // strict right turn drops the top
                if (r_lhs < r_rhs) begin
                    w_kctl.op = STK_POP;
                    n_depth   = r_depth - 1'b1;
                    n_state   = S_SC_TEST;
                end else begin
                    n_state = S_SC_PUSH;
                end
            end
            S_SC_PUSH: begin
                w_kctl.op = STK_PUSH;
                n_depth   = r_depth + 1'b1;
                n_state   = S_SC_NEXT;
            end
            S_ALIGN: begin
                // move the stack bottom into the last cell
                if (r_al == C_FULL) begin
                    n_state = S_EMIT_A;
                end else begin
                    w_kctl.op = STK_PUSH;
                    n_al      = r_al + 1'b1;
                end
            end
            S_EMIT_A: begin
                if (w_slot) begin
                    n_out      = r_anchor;
                    n_out_last = (r_depth == '0);
                    n_ov       = 1'b1;
                    n_em       = r_depth;
                    n_state    = S_EMIT_S;
                end
            end
            S_EMIT_S: begin
                if (r_em == '0) begin
                    n_cnt    = '0;
                    n_depth  = '0;
                    n_anchor = '1;
                    n_state  = S_LOAD;
                end else if (w_slot) begin
                    n_out      = w_kpt[C_MAX_POINTS-1];
                    n_out_last = (r_em == C_CNT_W'(1));
                    n_ov       = 1'b1;
                    n_em       = r_em - 1'b1;
                    w_kctl.op  = STK_PUSH;
                end
            end
            default: n_state = S_LOAD;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_LOAD;
            r_cnt    <= '0;
            r_depth  <= '0;
            r_anchor <= '1;
            r_ov     <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_cnt    <= n_cnt;
            r_depth  <= n_depth;
            r_anchor <= n_anchor;
            r_ov     <= n_ov;
        end
    end

    always_ff @(posedge i_clk) begin
        r_rd       <= n_rd;
        r_al       <= n_al;
        r_em       <= n_em;
        r_removed  <= n_removed;
        r_new      <= n_new;
        r_cur      <= n_cur;
        r_out      <= n_out;
        r_out_last <= n_out_last;
    end

    a_pop_needs_two: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == S_SC_DEC |-> r_depth > C_CNT_W'(1))
        else $error("turn test with fewer than two stacked points");

    a_cnt_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cnt <= C_FULL)
        else $error("point count past capacity");

    a_clean_on_load: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_pt.ready |-> (r_depth == '0) && !w_svld[0])
        else $error("loading with leftover sort or stack contents");

    a_stack_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == S_SC_PUSH |-> r_depth < C_FULL)
        else $error("stack push past capacity");

endmodule

>>> tb/convex_hull_graham_scan_tb.sv
// testbench for the convex hull block: predicted hull vertices checked against the output channel
`timescale 1ns / 100ps

module convex_hull_graham_scan_tb;
    import chp_pkg::*;

    localparam int WATCHDOG_LIMIT = 20000;

    logic i_clk;
    logic i_rst_n;

    chp_in_if  pt_if ();
    chp_out_if hull_if ();

    convex_hull_graham_scan DUT (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_pt    (pt_if.sink),
        .o_hull  (hull_if.source)
    );

    typedef struct {
        t_point pt;
        logic   last;
    } t_vertex;

    // predictor state
    t_point  pts[C_MAX_POINTS];
    int      pt_count;
    t_point  anchor;
    t_vertex hull_queue[$];

    int  errors;
    int  send_idle_pct;
    int  recv_stall_pct;
    bit  hold_off;
    int  idle_cycles;

    initial i_clk = 1'b0;
    always #4 i_clk = ~i_clk;

    function automatic longint angle_key(t_point o, t_point p, t_point q);
        longint lhs, rhs;
        lhs = (longint'(p.y) - longint'(o.y)) * (longint'(q.x) - longint'(o.x));
        rhs = (longint'(q.y) - longint'(o.y)) * (longint'(p.x) - longint'(o.x));
        return lhs - rhs;
    endfunction

    function automatic longint turn_val(t_point a, t_point b, t_point c);
        return (longint'(b.x) - longint'(a.x)) * (longint'(c.y) - longint'(a.y))
             - (longint'(b.y) - longint'(a.y)) * (longint'(c.x) - longint'(a.x));
    endfunction

    function automatic void clear_set();
        pt_count = 0;
        anchor.x = '1;
        anchor.y = '1;
    endfunction

    // works out the hull of the stored set and queues its vertices
    function automatic void predict_hull();
        t_point work[$];
        t_point stk[$];
        t_point t;
        bit removed;
        int j;
        removed = 0;
        for (int i = 0; i < pt_count; i++) begin
            if (!removed && pts[i] == anchor) begin
                removed = 1;
                continue;
            end
            work.push_back(pts[i]);
        end
        for (int i = 1; i < work.size(); i++) begin
            j = i;
            while (j > 0 && angle_key(anchor, work[j-1], work[j]) > 0) begin
                t = work[j]; work[j] = work[j-1]; work[j-1] = t;
                j--;
            end
        end
        foreach (work[i]) begin
            while (stk.size() > 1 &&
                   turn_val(stk[stk.size()-2], stk[stk.size()-1], work[i]) < 0)
                void'(stk.pop_back());
            stk.push_back(work[i]);
        end
        hull_queue.push_back('{anchor, stk.size() == 0});
        foreach (stk[i]) hull_queue.push_back('{stk[i], i == stk.size() - 1});
        clear_set();
    endfunction

    function automatic void note_point(t_point p, logic last);
        if (pt_count < C_MAX_POINTS) begin
            pts[pt_count] = p;
            pt_count++;
            if (p.y < anchor.y || (p.y == anchor.y && p.x < anchor.x)) anchor = p;
        end
        if (last) predict_hull();
    endfunction

    // sends one point request and waits for its acceptance
    task automatic send_point(logic [15:0] x, logic [15:0] y, logic last);
        while (send_idle_pct > 0 && $urandom_range(99) < send_idle_pct) begin
            pt_if.valid <= 1'b0;
            @(posedge i_clk);
        end
        pt_if.valid      <= 1'b1;
        pt_if.point_x    <= x;
        pt_if.point_y    <= y;
        pt_if.point_last <= last;
        @(posedge i_clk iff pt_if.ready);
        note_point('{x, y}, last);
    endtask

    task automatic wait_drain();
        pt_if.valid <= 1'b0;
        while (hull_queue.size() != 0) @(posedge i_clk);
        repeat (20) @(posedge i_clk);
    endtask

    task automatic send_random_set(int n, int span);
        int base_x, base_y;
        base_x = $urandom_range(16'hffff - span);
        base_y = $urandom_range(16'hffff - span);
        for (int i = 0; i < n; i++)
            send_point(16'(base_x + $urandom_range(span)), 16'(base_y + $urandom_range(span)),
                       i == n - 1);
    endtask

    task automatic test_directed();
        // single point
        send_point(16'h1234, 16'h5678, 1'b1);
        // coordinate extremes, square corners
        send_point(16'hffff, 16'hffff, 1'b0);
        send_point(16'h0000, 16'hffff, 1'b0);
        send_point(16'hffff, 16'h0000, 1'b0);
        send_point(16'h0000, 16'h0000, 1'b0);
        send_point(16'h8000, 16'h8000, 1'b1);
        // collinear points and anchor duplicates
        send_point(16'd10, 16'd10, 1'b0);
        send_point(16'd0, 16'd0, 1'b0);
        send_point(16'd20, 16'd20, 1'b0);
        send_point(16'd0, 16'd0, 1'b0);
        send_point(16'd30, 16'd0, 1'b0);
        send_point(16'd0, 16'd0, 1'b1);
        // two equal points
        send_point(16'h5555, 16'haaaa, 1'b0);
        send_point(16'h5555, 16'haaaa, 1'b1);
        wait_drain();
    endtask

    task automatic test_store_full();
        for (int i = 0; i < C_MAX_POINTS + 3; i++)
            send_point(16'($urandom), 16'($urandom), i == C_MAX_POINTS + 2);
        wait_drain();
    endtask

    task automatic test_random(int sender, int receiver, int items);
        int sent, n;
        send_idle_pct  = sender;
        recv_stall_pct = receiver;
        sent = 0;
        while (sent < items) begin
            n = ($urandom_range(9) == 0) ? $urandom_range(20, 40) : $urandom_range(1, 8);
            send_random_set(n, ($urandom_range(3) == 0) ? 16'hffff : $urandom_range(1, 64));
            sent += n;
        end
        wait_drain();
    endtask

    task automatic test_hold_off();
        send_idle_pct  = 0;
        recv_stall_pct = 0;
        fork
            begin
                hold_off = 1'b1;
                repeat (3000) @(posedge i_clk);
                hold_off = 1'b0;
            end
            begin
                send_random_set(12, 200);
                send_random_set(12, 200);
                send_random_set(6, 16'hffff);
                pt_if.valid <= 1'b0;
            end
        join
        wait_drain();
    endtask

    // receiver ready
    always @(posedge i_clk) begin
        if (!i_rst_n) hull_if.ready <= 1'b0;
        else hull_if.ready <= !hold_off && ($urandom_range(99) >= recv_stall_pct);
    end

    // result checker
    always @(posedge i_clk) begin
        t_vertex exp_v;
        if (i_rst_n && hull_if.valid && hull_if.ready) begin
            if (hull_queue.size() == 0) begin
                $display("%0t: unexpected vertex x=%h y=%h last=%b", $time,
                         hull_if.hull_x, hull_if.hull_y, hull_if.hull_last);
                errors++;
            end else begin
                exp_v = hull_queue.pop_front();
                if (hull_if.hull_x !== exp_v.pt.x || hull_if.hull_y !== exp_v.pt.y
                    || hull_if.hull_last !== exp_v.last) begin
                    $display("%0t: vertex mismatch expected x=%h y=%h last=%b, got x=%h y=%h last=%b",
                             $time, exp_v.pt.x, exp_v.pt.y, exp_v.last,
                             hull_if.hull_x, hull_if.hull_y, hull_if.hull_last);
                    errors++;
                end
            end
        end
    end

    // watchdog on cycles without any accepted request
    always @(posedge i_clk) begin
        if ((pt_if.valid && pt_if.ready) || (hull_if.valid && hull_if.ready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("Regression FAIL");
            $finish;
        end
    end

    initial begin
        errors         = 0;
        idle_cycles    = 0;
        send_idle_pct  = 0;
        recv_stall_pct = 0;
        hold_off       = 1'b0;
        clear_set();
        i_rst_n          = 1'b0;
        pt_if.valid      = 1'b0;
        pt_if.point_x    = '0;
        pt_if.point_y    = '0;
        pt_if.point_last = 1'b0;
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_directed();
        test_store_full();
        test_random(0, 0, 15);
        test_random(64, 0, 15);
        test_random(0, 64, 15);
        test_random(20, 20, 15);
        test_hold_off();

        wait_drain();
        if (errors == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end
endmodule
